// ----- hw/rtl/rwa_pkg.sv -----
package rwa_pkg;

    localparam int ID_W      = 16;
    localparam int ENTRY_W   = ID_W + 1;   // writer flag above the id
    localparam int ADM_W     = 5;
    localparam int MAX_ADMIT = 16;         // ids admitted by one finish, at most

    localparam logic [ID_W-1:0] FIRST_ID = 16'd2134;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_ADMITTED = 3'd0,
        ST_QUEUED   = 3'd1,
        ST_FINISHED = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REQ_SCAN,
        S_FIND_RD,
        S_FIND_CMP,
        S_ADM_START,
        S_ADM_HEAD,
        S_ADM_SCAN,
        S_ADM_COMMIT,
        S_FINAL
    } state_t;

endpackage

// ----- hw/rtl/rwa_ram.sv -----
module rwa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/reader_writer_admission.sv -----
// Reader/writer lock manager, writers take precedence.
//
// Input channel (in_valid / in_stall): op and target_id. A read or write
// request takes the next id (from 2134, wrapping at 16 bits) and yields one
// beat: admitted, queued or rejected when the store is full. A finish
// yields its own beat (finished or not found) and then one admitted beat
// for every queued id it lets run; last marks the final beat. Op code 3 is
// dropped with no beat.
// Output channel (out_valid / out_stall): one output register. A stall
// holds the beat and the sequencer waits at its next beat; nothing is lost.
// in_stall is high whenever the sequencer is busy with an item.
// Per item: a request that must wait (queued or rejected) goes straight to
// its final beat; one that goes for a run slot first searches for a free
// slot (free slot search walks the valid bits one slot a cycle). A finish
// walks the run-slot RAM, reading and comparing each occupied slot, then
// admits queued ids one by one, with one free slot search for the whole finish.
// Reset clears all valid bits, counters and pointers and sets the id to
// 2134; both RAMs need no clearing. No clearing pass.
module reader_writer_admission #(
    parameter int RUN_SLOTS   = 16,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [15:0] target_id,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] proc_id,
    output logic        is_writer,
    output logic        last
);

    localparam int SLOT_W = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
    localparam int CNT_W  = $clog2(RUN_SLOTS + 1);
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IW     = rwa_pkg::ID_W;
    localparam int EW     = rwa_pkg::ENTRY_W;
    localparam int AC_W   = rwa_pkg::ADM_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RUN_SLOTS - 1);
    localparam logic [PTR_W-1:0]  LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] Q_FULL    = QCNT_W'(QUEUE_DEPTH);
    localparam logic [AC_W-1:0]   ADM_LAST  = AC_W'(rwa_pkg::MAX_ADMIT - 1);

    rwa_pkg::state_t state_reg, state_next;

    logic [SLOT_W-1:0]    scan_reg, scan_next;     // request slot / finish search
    logic [SLOT_W-1:0]    free_reg, free_next;     // free slot search on admit
    logic [RUN_SLOTS-1:0] run_vld_reg, run_vld_next;
    logic [CNT_W-1:0]     run_cnt_reg, run_cnt_next;
    logic                 wr_run_reg, wr_run_next; // a writer holds the lock
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QCNT_W-1:0]    wait_cnt_reg, wait_cnt_next;
    logic [QCNT_W-1:0]    qw_cnt_reg, qw_cnt_next;
    logic [IW-1:0]        next_id_reg, next_id_next;
    logic [AC_W-1:0]      adm_cnt_reg, adm_cnt_next;

    // payload, no reset
    logic                 w_reg, w_next;
    logic [IW-1:0]        tid_reg, tid_next;
    logic [EW-1:0]        head_reg, head_next;
    logic [2:0]           res_status_reg, res_status_next;  // beat held back
    logic [IW-1:0]        res_id_reg, res_id_next;
    logic                 res_w_reg, res_w_next;

    logic                 out_valid_reg;
    logic [2:0]           out_status_reg;
    logic [IW-1:0]        out_id_reg;
    logic                 out_w_reg;
    logic                 out_last_reg;

    logic                 can_emit;
    logic                 emit_en;
    logic                 emit_last;

    logic                 r_we;
    logic [SLOT_W-1:0]    r_waddr;
    logic [EW-1:0]        r_wdata;
    logic [EW-1:0]        r_rdata;
    logic                 q_we;
    logic [EW-1:0]        q_wdata;
    logic [EW-1:0]        q_rdata;

    logic                 must_wait;
    logic                 req_w;

    rwa_ram #(.WIDTH(EW), .DEPTH(RUN_SLOTS)) u_run_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (scan_reg),
        .rdata (r_rdata)
    );

    rwa_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_wait_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (wr_ptr_reg),
        .wdata (q_wdata),
        .raddr (rd_ptr_reg),
        .rdata (q_rdata)
    );

    assign can_emit = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != rwa_pkg::S_IDLE);

    assign req_w     = op[0];
    assign must_wait = req_w ? (run_cnt_reg != '0)
                             : (wr_run_reg || (qw_cnt_reg != '0));

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        free_next       = free_reg;
        run_vld_next    = run_vld_reg;
        run_cnt_next    = run_cnt_reg;
        wr_run_next     = wr_run_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        wait_cnt_next   = wait_cnt_reg;
        qw_cnt_next     = qw_cnt_reg;
        next_id_next    = next_id_reg;
        adm_cnt_next    = adm_cnt_reg;
        w_next          = w_reg;
        tid_next        = tid_reg;
        head_next       = head_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_w_next      = res_w_reg;
        emit_en         = 1'b0;
        emit_last       = 1'b0;
        r_we            = 1'b0;
        r_waddr         = free_reg;
        r_wdata         = head_reg;
        q_we            = 1'b0;
        q_wdata         = {req_w, next_id_reg};

        case (state_reg)
            rwa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    case (op)
                        rwa_pkg::OP_READ, rwa_pkg::OP_WRITE:
                        begin
                            w_next       = req_w;
                            res_id_next  = next_id_reg;
                            res_w_next   = req_w;
                            next_id_next = next_id_reg + 1'b1;
                            if (must_wait)
                            begin
                                if (wait_cnt_reg >= Q_FULL)
                                begin
                                    res_status_next = rwa_pkg::ST_FULL;
                                end
                                else
                                begin
                                    q_we            = 1'b1;
                                    wr_ptr_next     = (wr_ptr_reg == LAST_PTR) ? '0
                                                    : wr_ptr_reg + 1'b1;
                                    wait_cnt_next   = wait_cnt_reg + 1'b1;
                                    qw_cnt_next     = qw_cnt_reg + QCNT_W'(req_w);
                                    res_status_next = rwa_pkg::ST_QUEUED;
                                end
                                state_next = rwa_pkg::S_FINAL;
                            end
                            else
                            begin
                                scan_next  = '0;
                                state_next = rwa_pkg::S_REQ_SCAN;
                            end
                        end
                        rwa_pkg::OP_FINISH:
                        begin
                            tid_next     = target_id;
                            scan_next    = '0;
                            free_next    = '0;
                            adm_cnt_next = '0;
                            state_next   = rwa_pkg::S_FIND_RD;
                        end
                        default:
                        begin
                            state_next = rwa_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            rwa_pkg::S_REQ_SCAN:
            begin
                if (!run_vld_reg[scan_reg])
                begin
                    r_we                   = 1'b1;
                    r_waddr                = scan_reg;
                    r_wdata                = {w_reg, res_id_reg};
                    run_vld_next[scan_reg] = 1'b1;
                    run_cnt_next           = run_cnt_reg + 1'b1;
                    wr_run_next            = wr_run_reg | w_reg;
                    res_status_next        = rwa_pkg::ST_ADMITTED;
                    state_next             = rwa_pkg::S_FINAL;
                end
                else if (scan_reg == LAST_SLOT)
                begin
                    res_status_next = rwa_pkg::ST_FULL;
                    state_next      = rwa_pkg::S_FINAL;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            rwa_pkg::S_FIND_RD:
            begin
                if (run_vld_reg[scan_reg])
                begin
                    state_next = rwa_pkg::S_FIND_CMP;
                end
                else if (scan_reg == LAST_SLOT)
                begin
                    res_status_next = rwa_pkg::ST_NOTFOUND;
                    res_id_next     = tid_reg;
                    res_w_next      = 1'b0;
                    state_next      = rwa_pkg::S_ADM_START;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            rwa_pkg::S_FIND_CMP:
            begin
                if (r_rdata[IW-1:0] == tid_reg)
                begin
                    run_vld_next[scan_reg] = 1'b0;
                    run_cnt_next           = run_cnt_reg - 1'b1;
                    if (r_rdata[IW])
                    begin
                        wr_run_next = 1'b0;
                    end
                    res_status_next = rwa_pkg::ST_FINISHED;
                    res_id_next     = tid_reg;
                    res_w_next      = r_rdata[IW];
                    state_next      = rwa_pkg::S_ADM_START;
                end
                else if (scan_reg == LAST_SLOT)
                begin
                    res_status_next = rwa_pkg::ST_NOTFOUND;
                    res_id_next     = tid_reg;
                    res_w_next      = 1'b0;
                    state_next      = rwa_pkg::S_ADM_START;
                end
                else
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = rwa_pkg::S_FIND_RD;
                end
            end

            // head read: address follows rd_ptr, data registered and taken in the next cycle
            rwa_pkg::S_ADM_START:
            begin
                state_next = (wait_cnt_reg == '0) ? rwa_pkg::S_FINAL : rwa_pkg::S_ADM_HEAD;
            end

            rwa_pkg::S_ADM_HEAD:
            begin
                head_next = q_rdata;
                if (q_rdata[IW])
                begin
                    state_next = (run_cnt_reg == '0) ? rwa_pkg::S_ADM_SCAN
                                                     : rwa_pkg::S_FINAL;
                end
                else
                begin
                    state_next = wr_run_reg ? rwa_pkg::S_FINAL : rwa_pkg::S_ADM_SCAN;
                end
            end

            // slots below free_reg stay taken during one finish
            rwa_pkg::S_ADM_SCAN:
            begin
                if (!run_vld_reg[free_reg])
                begin
                    state_next = rwa_pkg::S_ADM_COMMIT;
                end
                else if (free_reg == LAST_SLOT)
                begin
                    state_next = rwa_pkg::S_FINAL;
                end
                else
                begin
                    free_next = free_reg + 1'b1;
                end
            end

            rwa_pkg::S_ADM_COMMIT:
            begin
                if (can_emit)
                begin
                    emit_en                = 1'b1;
                    emit_last              = 1'b0;
                    res_status_next        = rwa_pkg::ST_ADMITTED;
                    res_id_next            = head_reg[IW-1:0];
                    res_w_next             = head_reg[IW];
                    r_we                   = 1'b1;
                    run_vld_next[free_reg] = 1'b1;
                    run_cnt_next           = run_cnt_reg + 1'b1;
                    wr_run_next            = wr_run_reg | head_reg[IW];
                    rd_ptr_next            = (rd_ptr_reg == LAST_PTR) ? '0
                                           : rd_ptr_reg + 1'b1;
                    wait_cnt_next          = wait_cnt_reg - 1'b1;
                    if (head_reg[IW] && (qw_cnt_reg != '0))
                    begin
                        qw_cnt_next = qw_cnt_reg - 1'b1;
                    end
                    adm_cnt_next = adm_cnt_reg + 1'b1;
                    if (head_reg[IW] || (adm_cnt_reg == ADM_LAST))
                    begin
                        state_next = rwa_pkg::S_FINAL;
                    end
                    else
                    begin
                        state_next = rwa_pkg::S_ADM_START;
                    end
                end
            end

            rwa_pkg::S_FINAL:
            begin
                if (can_emit)
                begin
                    emit_en    = 1'b1;
                    emit_last  = 1'b1;
                    state_next = rwa_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rwa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rwa_pkg::S_IDLE;
            scan_reg      <= '0;
            free_reg      <= '0;
            run_vld_reg   <= '0;
            run_cnt_reg   <= '0;
            wr_run_reg    <= 1'b0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            wait_cnt_reg  <= '0;
            qw_cnt_reg    <= '0;
            next_id_reg   <= rwa_pkg::FIRST_ID;
            adm_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            free_reg     <= free_next;
            run_vld_reg  <= run_vld_next;
            run_cnt_reg  <= run_cnt_next;
            wr_run_reg   <= wr_run_next;
            rd_ptr_reg   <= rd_ptr_next;
            wr_ptr_reg   <= wr_ptr_next;
            wait_cnt_reg <= wait_cnt_next;
            qw_cnt_reg   <= qw_cnt_next;
            next_id_reg  <= next_id_next;
            adm_cnt_reg  <= adm_cnt_next;
            if (emit_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg          <= w_next;
        tid_reg        <= tid_next;
        head_reg       <= head_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_w_reg      <= res_w_next;
        if (emit_en)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_w_reg      <= res_w_reg;
            out_last_reg   <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign proc_id   = out_id_reg;
    assign is_writer = out_w_reg;
    assign last      = out_last_reg;

    // a running writer is always alone
    a_writer_alone: assert property (@(posedge clk) disable iff (!rst_n)
        wr_run_reg |-> (run_cnt_reg == CNT_W'(1)))
        else $error("writer runs beside another process");

    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(run_vld_reg) == int'(run_cnt_reg))
        else $error("run count disagrees with valid bits");

    a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (qw_cnt_reg <= wait_cnt_reg) && (wait_cnt_reg <= Q_FULL))
        else $error("queue counters out of range");

    // a beat is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !emit_en)
        else $error("output beat overwritten while stalled");

endmodule
